// ----- src/modular_square_root_top_macros.svh -----
// assertion helpers used by the checks in msq_checker
`ifndef MODULAR_SQUARE_ROOT_TOP_MACROS_SVH
`define MODULAR_SQUARE_ROOT_TOP_MACROS_SVH

// property holds on every clock edge outside reset
`define MSQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/msq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_pkg
// shared widths and handshake types of the modular square root block
// ----------------------------------------------------------------------------
package msq_pkg;

	localparam int VALUE_BITS   = 32;
	localparam int S_TDATA_BITS = 64;
	localparam int M_TDATA_BITS = 32;

	// request to the modular multiplier
	typedef struct packed {
		logic start;
	} mm_ctl_t;

	// status back from the modular multiplier
	typedef struct packed {
		logic done;
	} mm_sts_t;

endpackage

// ----- src/msq_mulmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_mulmod
// bit-serial modular multiplier, one bit of b per cycle, msb first
// ----------------------------------------------------------------------------
module msq_mulmod #(
	parameter int W = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  msq_pkg::mm_ctl_t ctl,
	output msq_pkg::mm_sts_t sts,
	input  logic [W-1:0]    a,      // must be below p
	input  logic [W-1:0]    b,      // any value
	input  logic [W-1:0]    p,
	output logic [W-1:0]    res
);
	import msq_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic          done_q;
	logic [W:0]    dbl;
	logic [W:0]    red1;
	logic [W:0]    sum;
	logic [W-1:0]  nxt;

	// acc = 2*acc + bit*a, reduced twice by a compare and subtract
	always_comb begin
		dbl  = {acc_q, 1'b0};
		red1 = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
		sum  = red1 + (b_q[W-1] ? {1'b0, a_q} : '0);
		nxt  = (sum >= {1'b0, p}) ? W'(sum - {1'b0, p}) : W'(sum);
	end

	// sequencing of the w steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !ctl.start && (cnt_q == CW'(1));
			if (ctl.start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (cnt_q != '0) begin
			acc_q <= nxt;
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign sts.done = done_q;
	assign res      = acc_q;

endmodule

// ----- src/modular_square_root_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_square_root_top
// square root of a value modulo a prime by tonelli-shanks
// ----------------------------------------------------------------------------
// input stream: s_tdata carries value (bits 31:0) and modulus (bits 63:32);
// a transfer is taken while the block is idle (s_tready high).
// output stream: m_tdata carries root, one result per input item.
// all arithmetic uses one shared bit-serial modular multiplier; an
// exponentiation runs MODULUS_BITS square steps plus one multiply for every
// set exponent bit. zero value, modulus 2 and modulus below 2 finish
// straight after the check, without the multiplier; modulus 3 mod 4 takes
// a reduction and two exponentiations; other moduli add the non-residue
// search (one exponentiation per candidate), three more exponentiations
// and the order-reduction squarings.
// the block takes one item at a time; the next item may be taken while the
// result still waits in the output register. when the receiver stalls
// with a result pending, a finished item waits until the register frees.
// reset clears the sequencer and the output valid; no state is kept.
// ----------------------------------------------------------------------------
module modular_square_root_top #(
	parameter int MODULUS_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [msq_pkg::S_TDATA_BITS-1:0]   s_tdata,  // value, modulus
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [msq_pkg::M_TDATA_BITS-1:0]   m_tdata   // root
);
	import msq_pkg::*;

	localparam int W  = MODULUS_BITS;
	localparam int SW = $clog2(W);
	localparam int PW = $clog2(W + 1);
	localparam logic [W-1:0] ZLIM = W'((64'd1 << (W / 2)) + 64'd1);
	localparam logic [W-1:0] ONE  = W'(1);
	localparam logic [W-1:0] TWO  = W'(2);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHK, ST_RED, ST_EUL, ST_QS, ST_ZTEST, ST_ZCHK,
		ST_GOTC, ST_GOTT, ST_GOTR, ST_LOOP, ST_ISQ, ST_ISQD, ST_BSQ,
		ST_BSQD, ST_CSQ, ST_TMUL, ST_RMULD, ST_FINR, ST_FIN, ST_MWAIT,
		ST_PSQ, ST_PSQD, ST_PMD, ST_PNX
	} state_t;

	state_t        state_q, mret_q, pret_q;
	logic [W-1:0]  n_q, p_q, nr_q, q_q, z_q, c_q, t_q, r_q, tt_q, b_q, root_q;
	logic [SW-1:0] s_q, i_q, j_q;
	logic [W-1:0]  pbase_q, pexp_q, pacc_q;
	logic [PW-1:0] pcnt_q;
	logic [W-1:0]  ma_q, mb_q;
	logic          mm_run_q;
	logic          m_tvalid_q;
	logic [M_TDATA_BITS-1:0] m_tdata_q;
	mm_ctl_t       mm_ctl;
	mm_sts_t       mm_sts;
	logic [W-1:0]  mm_res;
	logic [W-1:0]  pm1;
	logic [SW:0]   jip1;

	assign pm1  = p_q - ONE;
	assign jip1 = {1'b0, j_q} + {1'b0, i_q} + (SW+1)'(1);

	// the multiplier starts in the first cycle of each wait
	assign mm_ctl.start = (state_q == ST_MWAIT) && !mm_run_q;

	msq_mulmod #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mm_ctl),
		.sts    (mm_sts),
		.a      (ma_q),
		.b      (mb_q),
		.p      (p_q),
		.res    (mm_res)
	);

	// sequencer: reduction, exponentiations and order reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mret_q     <= ST_IDLE;
			pret_q     <= ST_IDLE;
			mm_run_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						n_q     <= s_tdata[W-1:0];
						p_q     <= s_tdata[VALUE_BITS +: W];
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (n_q == '0 || p_q < TWO) begin
						root_q  <= '0;
						state_q <= ST_FIN;
					end else if (p_q == TWO) begin
						root_q  <= {{(W-1){1'b0}}, n_q[0]};
						state_q <= ST_FIN;
					end else begin
						ma_q <= ONE; mb_q <= n_q;
						mret_q <= ST_RED; state_q <= ST_MWAIT;
					end
				end
				ST_RED: begin
					nr_q <= mm_res;
					pbase_q <= mm_res; pexp_q <= pm1 >> 1; pacc_q <= ONE;
					pcnt_q <= PW'(W); pret_q <= ST_EUL; state_q <= ST_PSQ;
				end
				ST_EUL: begin
					if (pacc_q != ONE) begin
						root_q  <= '0;
						state_q <= ST_FIN;
					end else if (p_q[1:0] == 2'b11) begin
						pbase_q <= nr_q; pexp_q <= (p_q >> 2) + ONE; pacc_q <= ONE;
						pcnt_q <= PW'(W); pret_q <= ST_FINR; state_q <= ST_PSQ;
					end else begin
						q_q     <= pm1;
						s_q     <= '0;
						state_q <= ST_QS;
					end
				end
				// strip the factors of two from p-1
				ST_QS: begin
					if (!q_q[0]) begin
						q_q <= q_q >> 1;
						s_q <= s_q + 1'b1;
					end else begin
						z_q     <= TWO;
						state_q <= ST_ZTEST;
					end
				end
				// search for the smallest non-residue
				ST_ZTEST: begin
					if (z_q < p_q && z_q <= ZLIM) begin
						pbase_q <= z_q; pexp_q <= pm1 >> 1; pacc_q <= ONE;
						pcnt_q <= PW'(W); pret_q <= ST_ZCHK; state_q <= ST_PSQ;
					end else begin
						root_q  <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_ZCHK: begin
					if (pacc_q == pm1) begin
						pbase_q <= z_q; pexp_q <= q_q; pacc_q <= ONE;
						pcnt_q <= PW'(W); pret_q <= ST_GOTC; state_q <= ST_PSQ;
					end else begin
						z_q     <= z_q + ONE;
						state_q <= ST_ZTEST;
					end
				end
				ST_GOTC: begin
					c_q <= pacc_q;
					pbase_q <= nr_q; pexp_q <= q_q; pacc_q <= ONE;
					pcnt_q <= PW'(W); pret_q <= ST_GOTT; state_q <= ST_PSQ;
				end
				ST_GOTT: begin
					t_q <= pacc_q;
					pbase_q <= nr_q; pexp_q <= (q_q >> 1) + ONE; pacc_q <= ONE;
					pcnt_q <= PW'(W); pret_q <= ST_GOTR; state_q <= ST_PSQ;
				end
				ST_GOTR: begin
					r_q     <= pacc_q;
					state_q <= ST_LOOP;
				end
				// order reduction
				ST_LOOP: begin
					if (t_q == ONE) begin
						root_q  <= r_q;
						state_q <= ST_FIN;
					end else begin
						i_q     <= '0;
						tt_q    <= t_q;
						state_q <= ST_ISQ;
					end
				end
				ST_ISQ: begin
					if (tt_q != ONE && i_q < s_q) begin
						ma_q <= tt_q; mb_q <= tt_q;
						mret_q <= ST_ISQD; state_q <= ST_MWAIT;
					end else if (tt_q != ONE || i_q >= s_q) begin
						root_q  <= '0;
						state_q <= ST_FIN;
					end else begin
						j_q     <= '0;
						b_q     <= c_q;
						state_q <= ST_BSQ;
					end
				end
				ST_ISQD: begin
					tt_q    <= mm_res;
					i_q     <= i_q + 1'b1;
					state_q <= ST_ISQ;
				end
				ST_BSQ: begin
					ma_q <= b_q; mb_q <= b_q;
					state_q <= ST_MWAIT;
					if (jip1 < {1'b0, s_q}) begin
						mret_q <= ST_BSQD;
					end else begin
						s_q    <= i_q;
						mret_q <= ST_CSQ;
					end
				end
				ST_BSQD: begin
					b_q     <= mm_res;
					j_q     <= j_q + 1'b1;
					state_q <= ST_BSQ;
				end
				ST_CSQ: begin
					c_q <= mm_res;
					ma_q <= t_q; mb_q <= mm_res;
					mret_q <= ST_TMUL; state_q <= ST_MWAIT;
				end
				ST_TMUL: begin
					t_q <= mm_res;
					ma_q <= r_q; mb_q <= b_q;
					mret_q <= ST_RMULD; state_q <= ST_MWAIT;
				end
				ST_RMULD: begin
					r_q     <= mm_res;
					state_q <= ST_LOOP;
				end
				ST_FINR: begin
					root_q  <= pacc_q;
					state_q <= ST_FIN;
				end
				// hand the result to the output register
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_TDATA_BITS'(root_q);
						state_q    <= ST_IDLE;
					end
				end
				ST_MWAIT: begin
					mm_run_q <= !mm_sts.done;
					if (mm_sts.done) begin
						state_q <= mret_q;
					end
				end
				// exponentiation, exponent msb first
				ST_PSQ: begin
					ma_q <= pacc_q; mb_q <= pacc_q;
					mret_q <= ST_PSQD; state_q <= ST_MWAIT;
				end
				ST_PSQD: begin
					if (pexp_q[W-1]) begin
						ma_q <= mm_res; mb_q <= pbase_q;
						mret_q <= ST_PMD; state_q <= ST_MWAIT;
					end else begin
						pacc_q  <= mm_res;
						state_q <= ST_PNX;
					end
				end
				ST_PMD: begin
					pacc_q  <= mm_res;
					state_q <= ST_PNX;
				end
				ST_PNX: begin
					pexp_q <= {pexp_q[W-2:0], 1'b0};
					pcnt_q <= pcnt_q - 1'b1;
					if (pcnt_q == PW'(1)) begin
						state_q <= pret_q;
					end else begin
						state_q <= ST_PSQ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- src/msq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_checker
// port-level checks of the modular square root block
// ----------------------------------------------------------------------------
`include "modular_square_root_top_macros.svh"

module msq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [msq_pkg::S_TDATA_BITS-1:0] s_tdata,   // value, modulus
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [msq_pkg::M_TDATA_BITS-1:0] m_tdata    // root
);
	import msq_pkg::*;

	// a pending result holds until taken
	`MSQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

	// an accepted item makes the block busy in the next cycle
	`MSQ_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

	// a new result only appears while an item is in work
	`MSQ_ASSERT(a_res_busy, $rose(m_tvalid) |-> $past(!s_tready), "result without an item in work")

endmodule

bind modular_square_root_top msq_checker u_msq_checker (.*);

// ----- verif/modular_square_root_top_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_square_root_top_checker
// Watches both stream channels of the modular square root block. Every
// accepted value and modulus is turned into an expected root by a
// tonelli-shanks predictor. Each returned root is compared in order with
// those expected roots.
// ----------------------------------------------------------------------------
module modular_square_root_top_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [msq_pkg::S_TDATA_BITS-1:0] s_tdata,  // value, modulus
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [msq_pkg::M_TDATA_BITS-1:0] m_tdata,  // root
	output int                               errors,
	output int                               pending,
	output int                               roots_checked
);

	localparam longint unsigned ZLIMIT = (64'd1 << 16) + 1;

	logic [31:0] root_q[$];

	function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
			longint unsigned m);
		return (a * b) % m;
	endfunction

	function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		longint unsigned b;
		acc = 1 % m;
		b = base % m;
		while (e != 0) begin
			if (e[0]) acc = mul_mod(acc, b, m);
			b = mul_mod(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// square root of n modulo p, 0 for zero, non-residue or failed search
	function automatic logic [31:0] predict_root(logic [31:0] n32, logic [31:0] p32);
		longint unsigned n, p, nr, q, s, z, c, t, r, i, tt, b, j;
		bit found;
		n = 64'(n32);
		p = 64'(p32);
		found = 0;
		if (n == 0) return 32'd0;
		if (p == 2) return 32'(n & 1);
		if (p < 2) return 32'd0;
		nr = n % p;
		if (pow_mod(nr, (p - 1) / 2, p) != 1) return 32'd0;
		if ((p & 3) == 3) return 32'(pow_mod(nr, (p + 1) / 4, p));
		q = p - 1;
		s = 0;
		while (q[0] == 0) begin
			q = q >> 1;
			s++;
		end
		// smallest non-residue, bounded for composite moduli
		z = 2;
		while (z < p && z <= ZLIMIT && !found) begin
			if (pow_mod(z, (p - 1) / 2, p) == p - 1) found = 1;
			else z++;
		end
		if (!found) return 32'd0;
		c = pow_mod(z, q, p);
		t = pow_mod(nr, q, p);
		r = pow_mod(nr, (q + 1) / 2, p);
		// order reduction
		while (t != 1) begin
			i = 0;
			tt = t;
			b = c;
			while (tt != 1 && i < s) begin
				tt = mul_mod(tt, tt, p);
				i++;
			end
			if (tt != 1 || i >= s) return 32'd0;
			for (j = 0; j + i + 1 < s; j++) b = mul_mod(b, b, p);
			s = i;
			c = mul_mod(b, b, p);
			t = mul_mod(t, c, p);
			r = mul_mod(r, b, p);
		end
		return r[31:0];
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: root mismatch (%s): got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q.delete();
			errors         = 0;
			pending       <= 0;
			roots_checked <= 0;
		end else begin
			if (s_tvalid && s_tready)
				root_q.push_back(predict_root(s_tdata[31:0], s_tdata[63:32]));
			if (m_tvalid && m_tready) begin
				if (root_q.size() == 0) begin
					report_mismatch("no root expected", m_tdata, '0);
				end else begin
					if (m_tdata !== root_q[0]) report_mismatch("root", m_tdata, root_q[0]);
					void'(root_q.pop_front());
					roots_checked <= roots_checked + 1;
				end
			end
			pending <= root_q.size();
		end
	end

endmodule

// ----- verif/modular_square_root_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_square_root_top_test
// Drives value and modulus pairs into the modular square root block: a
// directed set of corners first, then a random mix. The mix covers primes
// of many widths, residues, small composites, modulus 2 and zero values.
// The sender works in bursts, the receiver stalls, and a checker compares
// every root.
// ----------------------------------------------------------------------------
module modular_square_root_top_test;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;  // value, modulus
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // root

	int  errors;
	int  pending;
	int  roots_checked;
	int  burst_left;
	int  items_sent;
	int  primes_sent;
	bit  hold_req;

	modular_square_root_top #(.MODULUS_BITS(32)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	modular_square_root_top_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending), .roots_checked(roots_checked)
	);

	always #4 clk = ~clk;

	// hard stop
	initial begin
		#400_000_000;
		$display("modular_square_root_top_test: FAIL");
		$finish;
	end

	// miller-rabin with bases 2, 7, 61 is exact below 2^32
	function automatic longint unsigned exp_mod(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		acc = 1;
		b = b % m;
		while (e != 0) begin
			if (e[0]) acc = (acc * b) % m;
			b = (b * b) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic bit is_prime(longint unsigned x);
		longint unsigned d, y, a;
		int s, k, w;
		longint unsigned bases[3];
		bit comp;
		bases = '{2, 7, 61};
		if (x < 2) return 0;
		if (x == 2 || x == 3 || x == 7 || x == 61) return 1;
		if (x[0] == 0) return 0;
		d = x - 1;
		s = 0;
		while (d[0] == 0) begin
			d = d >> 1;
			s++;
		end
		for (k = 0; k < 3; k++) begin
			a = bases[k] % x;
			if (a == 0) continue;
			y = exp_mod(a, d, x);
			if (y == 1 || y == x - 1) continue;
			comp = 1;
			for (w = 1; w < s; w++) begin
				y = (y * y) % x;
				if (y == x - 1) comp = 0;
				if (y == x - 1) break;
			end
			if (comp) return 0;
		end
		return 1;
	endfunction

	// random odd prime with its top bit at width-1
	function automatic logic [31:0] rand_prime(int width);
		longint unsigned x;
		do begin
			x = {$urandom, $urandom} & ((64'd1 << width) - 1);
			x = x | (64'd1 << (width - 1)) | 1;
		end while (!is_prime(x));
		return x[31:0];
	endfunction

	task automatic push_item(logic [31:0] value, logic [31:0] modulus);
		if (burst_left == 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		s_tvalid = 1;
		s_tdata  = {modulus, value};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid = 0;
		while (pending != 0) @(negedge clk);
	endtask

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin
		int mode;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready = 0;
				repeat (20000) @(negedge clk);
				hold_req = 0;
			end
			mode = $urandom_range(0, 2);
			repeat (64) begin
				@(negedge clk);
				case (mode)
					0: m_tready = 1;
					1: m_tready = $urandom_range(0, 1);
					default: m_tready = ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin
		logic [31:0] p, v;
		longint unsigned x;
		int pick;
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		hold_req = 0;
		burst_left = 0;
		items_sent = 0;
		primes_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed corners
		push_item(0, 7);                 // zero value
		push_item(5, 2);                 // modulus 2, odd value
		push_item(4, 2);                 // modulus 2, even value
		push_item(3, 0);                 // modulus zero
		push_item(3, 1);                 // modulus one
		push_item(13, 13);               // nonzero multiple of the modulus
		push_item(2, 7);                 // residue, 3 mod 4
		push_item(3, 7);                 // non-residue
		push_item(32'hFFFF_FFFF, 13);    // value above the modulus
		push_item(32'hFFFF_FFFF, 32'd4294967291);
		push_item(2, 32'd4294967291);
		push_item(4, 17);                // 1 mod 4, order reduction
		push_item(2, 41);
		push_item(7, 5);
		push_item(1, 32'd3221225473);    // deep power of two in p-1
		push_item(5, 32'd3221225473);
		push_item(9, 32'd3221225473);
		push_item(4, 32'd998244353);
		push_item(10, 32'd2013265921);
		push_item(4, 9);                 // small composite modulus
		push_item(1, 15);
		push_item(4, 21);
		push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();

		// random mix
		for (int k = 0; k < 127; k++) begin
			if (k == 60) hold_req = 1;
			if (k == 110) wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				v = 0;
				p = $urandom;
			end else if (pick < 15) begin
				v = $urandom;
				p = 2;
			end else if (pick < 22) begin
				v = $urandom_range(2, 32'hFFFF_FFFF);
				p = $urandom;
			end else if (pick < 32) begin
				p = $urandom_range(1, 100) * 2 + 1;
				v = $urandom;
			end else begin
				p = rand_prime($urandom_range(3, 32));
				primes_sent++;
				if ($urandom_range(0, 1)) begin
					// residue: square of a random number, sometimes shifted by p
					x = $urandom % p;
					x = (x * x) % p;
					if ($urandom_range(0, 1) && x + p <= 64'hFFFF_FFFF) x = x + p;
					v = x[31:0];
				end else begin
					v = $urandom;
				end
			end
			push_item(v, p);
		end

		wait_drained();
		repeat (200) @(posedge clk);
		$display("covered %0d items (%0d random primes) and checked %0d roots,",
			items_sent, primes_sent, roots_checked);
		$display("with bursts, receiver stalls, one long hold-off and drained pauses");
		if (errors == 0)
			$display("modular_square_root_top_test: PASS");
		else
			$display("modular_square_root_top_test: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/msq_pkg.sv
src/msq_mulmod.sv
src/modular_square_root_top.sv
src/msq_checker.sv
verif/modular_square_root_top_checker.sv
verif/modular_square_root_top_test.sv
